>>> rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg: shared definitions for the MIPS R3000 subset core
// Opcodes, function codes, bus and status codes, reset constants and types.
// ----------------------------------------------------------------------------
package msc_pkg;

   typedef logic [31:0] word_type;
   typedef logic [1:0]  bus_op_type;
   typedef logic [2:0]  status_type;
   typedef logic [4:0]  reg_idx_type;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDI_NOTRAP = 6'h09;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2B;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_OR      = 6'h25;

   localparam reg_idx_type COP_MTC0  = 5'd4;
   localparam reg_idx_type SR_INDEX  = 5'd12;
   localparam int unsigned ISOLATE_BIT = 16;

   localparam word_type JUMP_MASK    = 32'hF000_0000;
   localparam word_type FILL_VALUE   = 32'hDEAD_BEEF;
   localparam word_type RESET_PC     = 32'hBFC0_0000;

   localparam logic       REQ_CYCLE  = 1'b0;
   localparam logic       REQ_LOAD   = 1'b1;

   localparam bus_op_type BUS_NONE   = 2'd0;
   localparam bus_op_type BUS_READ   = 2'd1;
   localparam bus_op_type BUS_WRITE  = 2'd2;

   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_BAD_OP  = 3'd1;
   localparam status_type ST_BAD_COP = 3'd2;
   localparam status_type ST_OVF     = 3'd3;
   localparam status_type ST_IGNORED = 3'd4;

endpackage

>>> rtl/msc_if.sv
// ----------------------------------------------------------------------------
// msc_if: valid/ready channels of the MIPS R3000 subset core
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface msc_req_if;
   import msc_pkg::*;
   logic     valid;
   logic     ready;
   logic     req_type;
   word_type data_word;
   modport source (output valid, output req_type, output data_word, input ready);
   modport sink   (input valid, input req_type, input data_word, output ready);
endinterface

interface msc_rsp_if;
   import msc_pkg::*;
   logic       valid;
   logic       ready;
   word_type   fetch_addr;
   bus_op_type bus_op;
   word_type   bus_addr;
   word_type   bus_wdata;
   status_type status;
   modport source (output valid, output fetch_addr, output bus_op, output bus_addr,
                   output bus_wdata, output status, input ready);
   modport sink   (input valid, input fetch_addr, input bus_op, input bus_addr,
                   input bus_wdata, input status, output ready);
endinterface

interface msc_csr_if;
   import msc_pkg::*;
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/mips_r3000_subset_core.sv
// ----------------------------------------------------------------------------
// mips_r3000_subset_core: small MIPS R3000 integer core
// Executes SLL, OR, LUI, ORI, ADDI, ADDIU, J, BNE, LW, SW and MTC0 (status).
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries one word per item: a fetched instruction word for the
//  address last shown on fetch_addr (req_type 0), or LW read data (req_type 1).
//  Each accepted word yields one response word on rsp_chan: next fetch
//  address, data bus request, and a status code.
//  After a response with a data read request, the load data word must come
//  before the next fetched word; out-of-order words are answered as ignored.
//  csr_chan writes the start address; it also reloads the program counter.
//  Response: registered, valid in the cycle after acceptance.
//  Throughput: one word per cycle. Operands of the prefetched instruction
//  are read from the register file RAM at the edge that delivers the word,
//  with the same-edge writeback forwarded, so execution never waits.
//  Reset: pc = 0xBFC00000, prefetch holds a nop, r1..r31 read 0xDEADBEEF
//  through per-entry valid bits, status register clear, core running.
//  Stall: req_chan.ready drops while the response register is full and the
//  receiver is not ready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mips_r3000_subset_core (
   input  logic      clock,
   input  logic      reset,
   msc_req_if.sink   req_chan,
   msc_rsp_if.source rsp_chan,
   msc_csr_if.sink   csr_chan
);
   import msc_pkg::*;

   // control state
   word_type    pc_ff, pc_in;
   word_type    pw_ff;
   logic        iso_ff, iso_in;
   logic        awaiting_ff, awaiting_in;
   logic        halted_ff, halted_in;
   reg_idx_type pl_reg_ff, pl_reg_in;

   // register file RAM and read side
   word_type    regfile_ff [32];
   logic [31:0] rf_valid_ff;
   word_type    rd_s_ff, rd_t_ff;
   logic        rv_s_ff, rv_t_ff;
   logic        fwd_en_ff;
   reg_idx_type fwd_addr_ff;
   word_type    fwd_data_ff;

   // response register
   logic        rsp_valid_ff;
   word_type    rsp_fetch_ff, rsp_fetch_in;
   bus_op_type  rsp_op_ff, rsp_op_in;
   word_type    rsp_addr_ff, rsp_addr_in;
   word_type    rsp_wdata_ff, rsp_wdata_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic        req_fire, exec_fire, load_fire, csr_fire;
   logic        wr_en;
   reg_idx_type wr_addr;
   word_type    wr_data;

   // decode
   logic [5:0]  opc, funct;
   reg_idx_type rs, rt, rd, shamt;
   word_type    simm, vs, vt, sum, pc_plus4, br_target, j_target;
   word_type    ex_pc, ex_val, ex_addr, ex_wdata;
   reg_idx_type ex_dest;
   status_type  ex_code;
   bus_op_type  ex_op;
   logic        ex_load;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign csr_fire  = csr_chan.valid;
   assign exec_fire = req_fire && !halted_ff && !awaiting_ff && (req_chan.req_type == REQ_CYCLE);
   assign load_fire = req_fire && !halted_ff && awaiting_ff && (req_chan.req_type == REQ_LOAD);

   assign opc   = pw_ff[31:26];
   assign rs    = pw_ff[25:21];
   assign rt    = pw_ff[20:16];
   assign rd    = pw_ff[15:11];
   assign shamt = pw_ff[10:6];
   assign funct = pw_ff[5:0];
   assign simm  = {{16{pw_ff[15]}}, pw_ff[15:0]};

   // operand values as of before this step
   always_comb begin
      if (rs == 5'd0) begin
         vs = '0;
      end else if (fwd_en_ff && (fwd_addr_ff == rs)) begin
         vs = fwd_data_ff;
      end else begin
         vs = rv_s_ff ? rd_s_ff : FILL_VALUE;
      end
      if (rt == 5'd0) begin
         vt = '0;
      end else if (fwd_en_ff && (fwd_addr_ff == rt)) begin
         vt = fwd_data_ff;
      end else begin
         vt = rv_t_ff ? rd_t_ff : FILL_VALUE;
      end
   end

   assign sum       = vs + simm;
   assign pc_plus4  = pc_ff + 32'd4;
   assign br_target = pc_ff + {simm[29:0], 2'b00};
   assign j_target  = (pc_ff & JUMP_MASK) | {4'b0000, pw_ff[25:0], 2'b00};

   always_comb begin
      ex_pc    = pc_plus4;
      ex_dest  = '0;
      ex_val   = '0;
      ex_code  = ST_OK;
      ex_op    = BUS_NONE;
      ex_addr  = '0;
      ex_wdata = '0;
      ex_load  = 1'b0;
      iso_in   = iso_ff;
      unique case (opc)
         OP_SPECIAL: begin
            if (funct == FN_SLL) begin
               ex_dest = rd;
               ex_val  = vt << shamt;
            end else if (funct == FN_OR) begin
               ex_dest = rd;
               ex_val  = vs | vt;
            end else begin
               ex_code = ST_BAD_OP;
            end
         end
         OP_LUI: begin
            ex_dest = rt;
            ex_val  = {pw_ff[15:0], 16'h0000};
         end
         OP_ORI: begin
            ex_dest = rt;
            ex_val  = vs | {16'h0000, pw_ff[15:0]};
         end
         OP_ADDI_NOTRAP: begin
            ex_dest = rt;
            ex_val  = sum;
         end
         OP_ADDI: begin
            ex_val = sum;
            if (((vs[31] ^ sum[31]) & (simm[31] ^ sum[31])) == 1'b1) begin
               ex_code = ST_OVF;
            end else begin
               ex_dest = rt;
            end
         end
         OP_J: begin
            ex_pc = j_target;
         end
         OP_BNE: begin
            if (vs != vt) begin
               ex_pc = br_target;
            end
         end
         OP_LW: begin
            if (!iso_ff) begin
               ex_op   = BUS_READ;
               ex_addr = sum;
               ex_load = 1'b1;
            end
         end
         OP_SW: begin
            if (!iso_ff) begin
               ex_op    = BUS_WRITE;
               ex_addr  = sum;
               ex_wdata = vt;
            end
         end
         OP_COP0: begin
            if (rs != COP_MTC0) begin
               ex_code = ST_BAD_OP;
            end else if (rd != SR_INDEX) begin
               ex_code = ST_BAD_COP;
            end else begin
               iso_in = vt[ISOLATE_BIT];
            end
         end
         default: begin
            ex_code = ST_BAD_OP;
         end
      endcase
   end

   // register file write port: instruction writeback or returned load data
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ex_dest;
      wr_data = ex_val;
      if (exec_fire) begin
         wr_en = (ex_code == ST_OK) && (ex_dest != 5'd0);
      end else if (load_fire) begin
         wr_en   = (pl_reg_ff != 5'd0);
         wr_addr = pl_reg_ff;
         wr_data = req_chan.data_word;
      end
   end

   always_comb begin
      pc_in       = pc_ff;
      halted_in   = halted_ff;
      awaiting_in = awaiting_ff;
      pl_reg_in   = pl_reg_ff;
      if (csr_fire) begin
         pc_in = csr_chan.data;
      end
      if (exec_fire) begin
         pc_in       = ex_pc;
         halted_in   = (ex_code != ST_OK);
         awaiting_in = ex_load;
         pl_reg_in   = ex_load ? rt : 5'd0;
      end else if (load_fire) begin
         awaiting_in = 1'b0;
      end
   end

   always_comb begin
      rsp_fetch_in  = exec_fire ? ex_pc : pc_ff;
      rsp_op_in     = BUS_NONE;
      rsp_addr_in   = '0;
      rsp_wdata_in  = '0;
      rsp_status_in = ST_OK;
      if (exec_fire) begin
         rsp_op_in     = ex_op;
         rsp_addr_in   = ex_addr;
         rsp_wdata_in  = ex_wdata;
         rsp_status_in = ex_code;
      end else if (!load_fire) begin
         rsp_status_in = ST_IGNORED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= RESET_PC;
         pw_ff        <= '0;
         iso_ff       <= 1'b0;
         awaiting_ff  <= 1'b0;
         halted_ff    <= 1'b0;
         pl_reg_ff    <= '0;
         rf_valid_ff  <= '0;
         fwd_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff       <= pc_in;
         awaiting_ff <= awaiting_in;
         halted_ff   <= halted_in;
         pl_reg_ff   <= pl_reg_in;
         if (exec_fire) begin
            pw_ff     <= req_chan.data_word;
            iso_ff    <= iso_in;
            fwd_en_ff <= wr_en;
         end
         if (wr_en) begin
            rf_valid_ff[wr_addr] <= 1'b1;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regfile_ff[wr_addr] <= wr_data;
      end
      if (exec_fire) begin
         rd_s_ff     <= regfile_ff[req_chan.data_word[25:21]];
         rd_t_ff     <= regfile_ff[req_chan.data_word[20:16]];
         rv_s_ff     <= rf_valid_ff[req_chan.data_word[25:21]];
         rv_t_ff     <= rf_valid_ff[req_chan.data_word[20:16]];
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
      if (req_fire) begin
         rsp_fetch_ff  <= rsp_fetch_in;
         rsp_op_ff     <= rsp_op_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_wdata_ff  <= rsp_wdata_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.fetch_addr = rsp_fetch_ff;
   assign rsp_chan.bus_op     = rsp_op_ff;
   assign rsp_chan.bus_addr   = rsp_addr_ff;
   assign rsp_chan.bus_wdata  = rsp_wdata_ff;
   assign rsp_chan.status     = rsp_status_ff;

`ifndef SYNTH
   a_halted_ignores: assert property (@(posedge clock) disable iff (reset)
      (req_fire && halted_ff) |=>
         (rsp_chan.status == ST_IGNORED) && (rsp_chan.bus_op == BUS_NONE))
      else $error("halted core answered a word as executed");

   a_read_waits: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (ex_op == BUS_READ)) |=> awaiting_ff)
      else $error("read request without waiting for load data");

   a_pc_holds_on_wait: assert property (@(posedge clock) disable iff (reset)
      (req_fire && awaiting_ff && !csr_fire) |=> $stable(pc_ff))
      else $error("pc moved while load data was outstanding");

   a_no_exec_write_on_wait: assert property (@(posedge clock) disable iff (reset)
      (awaiting_ff && wr_en) |-> load_fire)
      else $error("register write while load data was outstanding");
`endif

endmodule

>>> bench/mips_r3000_subset_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mips_r3000_subset_core_tb: self-checking bench for the R3000 subset core
// A queue of request words (fetched instructions and load returns) feeds a
// clocked driver. Each word is run through a cycle-free model of the core
// when it is queued; the model response is moved to the due queue when the
// word is accepted. A clocked monitor checks every response word against the
// oldest due entry. Phases: directed program at the reset start address,
// then random programs under several start addresses, then one halting
// fault followed by words that must be ignored.
// ----------------------------------------------------------------------------
module mips_r3000_subset_core_tb;
   import msc_pkg::*;

   typedef struct packed {
      word_type   fetch_addr;
      bus_op_type bus_op;
      word_type   bus_addr;
      word_type   bus_wdata;
      status_type status;
   } core_rsp_type;

   typedef struct {
      logic         kind;
      word_type     word;
      logic         drain;
      core_rsp_type rsp;
   } core_word_type;

   typedef enum {
      FLT_OPCODE, FLT_FUNCT, FLT_COP_OP, FLT_COP_REG, FLT_OVF_UP, FLT_OVF_DOWN
   } fault_kind_type;

   logic clock;
   logic reset;

   msc_req_if req_bus ();
   msc_rsp_if rsp_bus ();
   msc_csr_if csr_bus ();

   mips_r3000_subset_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // core model state
   word_type    cpu_gpr [32];
   word_type    cpu_pc;
   word_type    cpu_start_pc;
   word_type    cpu_prefetch;
   word_type    cpu_sr;
   reg_idx_type cpu_load_reg;
   word_type    cpu_load_val;
   logic        cpu_wait_load;
   logic        cpu_halted;

   core_word_type word_feed_q [$];
   core_rsp_type  rsp_due_q [$];

   logic        calm;
   int          gap_left;
   int          stall_left;
   int          n_words;
   int          n_loads;
   int          n_checked;
   int          n_bad;
   int          n_cfg;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("timeout: %0d responses still due", rsp_due_q.size());
      $display("mips_r3000_subset_core test failed");
      $finish;
   end

   function automatic core_rsp_type exec_prefetch(word_type fetched);
      core_rsp_type r;
      word_type    ins, vs, vt, simm, val, slot;
      logic [5:0]  opc;
      reg_idx_type rs, rt, rd, dest;
      status_type  code;
      r    = '0;
      ins  = cpu_prefetch;
      opc  = ins[31:26];
      rs   = ins[25:21];
      rt   = ins[20:16];
      rd   = ins[15:11];
      vs   = cpu_gpr[rs];
      vt   = cpu_gpr[rt];
      simm = {{16{ins[15]}}, ins[15:0]};
      dest = '0;
      val  = '0;
      code = ST_OK;
      slot = cpu_pc;
      cpu_prefetch = fetched;
      if (cpu_load_reg != 0) cpu_gpr[cpu_load_reg] = cpu_load_val;
      cpu_load_reg = '0;
      cpu_load_val = '0;
      cpu_pc = cpu_pc + 32'd4;
      case (opc)
         OP_SPECIAL: begin
            if (ins[5:0] == FN_SLL) begin
               dest = rd;
               val  = vt << ins[10:6];
            end else if (ins[5:0] == FN_OR) begin
               dest = rd;
               val  = vs | vt;
            end else begin
               code = ST_BAD_OP;
            end
         end
         OP_LUI: begin
            dest = rt;
            val  = {ins[15:0], 16'h0000};
         end
         OP_ORI: begin
            dest = rt;
            val  = vs | {16'h0000, ins[15:0]};
         end
         OP_ADDI_NOTRAP: begin
            dest = rt;
            val  = vs + simm;
         end
         OP_ADDI: begin
            val = vs + simm;
            if (vs[31] == simm[31] && val[31] != vs[31]) code = ST_OVF;
            else dest = rt;
         end
         OP_J: cpu_pc = (slot & JUMP_MASK) | {4'h0, ins[25:0], 2'b00};
         OP_BNE: begin
            if (vs != vt) cpu_pc = slot + (simm << 2);
         end
         OP_LW: begin
            if (!cpu_sr[ISOLATE_BIT]) begin
               r.bus_op      = BUS_READ;
               r.bus_addr    = vs + simm;
               cpu_load_reg  = rt;
               cpu_wait_load = 1'b1;
            end
         end
         OP_SW: begin
            if (!cpu_sr[ISOLATE_BIT]) begin
               r.bus_op    = BUS_WRITE;
               r.bus_addr  = vs + simm;
               r.bus_wdata = vt;
            end
         end
         OP_COP0: begin
            if (rs != COP_MTC0) code = ST_BAD_OP;
            else if (rd != SR_INDEX) code = ST_BAD_COP;
            else cpu_sr = vt;
         end
         default: code = ST_BAD_OP;
      endcase
      if (code != ST_OK) cpu_halted = 1'b1;
      else if (dest != 0) cpu_gpr[dest] = val;
      r.status = code;
      return r;
   endfunction

   function automatic core_rsp_type step_core(logic kind, word_type w);
      core_rsp_type r;
      r = '0;
      if (cpu_halted) begin
         r.status = ST_IGNORED;
      end else if (kind == REQ_LOAD) begin
         if (cpu_wait_load) begin
            cpu_load_val  = w;
            cpu_wait_load = 1'b0;
         end else begin
            r.status = ST_IGNORED;
         end
      end else if (cpu_wait_load) begin
         r.status = ST_IGNORED;
      end else begin
         r = exec_prefetch(w);
      end
      r.fetch_addr = cpu_pc;
      return r;
   endfunction

   function automatic void feed(logic kind, word_type w, logic drain);
      core_word_type it;
      it.kind  = kind;
      it.word  = w;
      it.drain = drain;
      it.rsp   = step_core(kind, w);
      word_feed_q.push_back(it);
   endfunction

   // fetch word, followed by the load return when executing the prefetch started a read
   function automatic void feed_insn(word_type w, word_type load_data);
      feed(REQ_CYCLE, w, 1'b0);
      if (cpu_wait_load && !cpu_halted) feed(REQ_LOAD, load_data, 1'b0);
   endfunction

   function automatic word_type enc_i(logic [5:0] opc, reg_idx_type rs, reg_idx_type rt,
                                      logic [15:0] imm);
      return {opc, rs, rt, imm};
   endfunction

   function automatic word_type enc_r(reg_idx_type rs, reg_idx_type rt, reg_idx_type rd,
                                      logic [4:0] sh, logic [5:0] fn);
      return {OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic word_type enc_mtc0(reg_idx_type rt);
      return {OP_COP0, COP_MTC0, rt, SR_INDEX, 11'h000};
   endfunction

   function automatic reg_idx_type pick_reg();
      if ($urandom_range(0, 1) == 0) return reg_idx_type'($urandom_range(0, 3));
      return reg_idx_type'($urandom_range(0, 31));
   endfunction

   function automatic logic [15:0] pick_imm();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'h7FFF;
         2:       return 16'h8000;
         3:       return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic word_type rand_data();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic word_type rand_insn();
      word_type    fill;
      reg_idx_type rs, rt, rd;
      logic [15:0] imm;
      fill = $urandom();
      rs   = pick_reg();
      rt   = pick_reg();
      rd   = pick_reg();
      imm  = pick_imm();
      case ($urandom_range(0, 14))
         0, 1:    return enc_r(rs, rt, rd, fill[10:6], FN_SLL);
         2, 3:    return enc_r(rs, rt, rd, fill[10:6], FN_OR);
         4:       return enc_i(OP_LUI, rs, rt, imm);
         5:       return enc_i(OP_ORI, rs, rt, imm);
         6:       return enc_i(OP_ADDI_NOTRAP, rs, rt, imm);
         7, 8:    return enc_i(OP_ADDI, rs, rt, imm);
         9:       return {OP_J, fill[25:0]};
         10:      return enc_i(OP_BNE, rs, rt, imm);
         11, 12:  return enc_i(OP_LW, rs, rt, imm);
         13:      return enc_i(OP_SW, rs, rt, imm);
         default: return {OP_COP0, COP_MTC0, rt, SR_INDEX, fill[10:0]};
      endcase
   endfunction

   task automatic random_phase(int count);
      int       pause_at;
      int       k;
      word_type vs, simm, sum;
      pause_at = $urandom_range(0, count - 1);
      for (k = 0; k < count; k++) begin
         if (cpu_wait_load) begin
            if ($urandom_range(0, 11) == 0) feed(REQ_CYCLE, $urandom(), k == pause_at);
            else feed(REQ_LOAD, rand_data(), k == pause_at);
         end else if ($urandom_range(0, 19) == 0) begin
            feed(REQ_LOAD, rand_data(), k == pause_at);
         end else begin
            feed(REQ_CYCLE, rand_insn(), k == pause_at);
            // the new prefetch reads these registers next; keep ADDI from halting
            if (cpu_prefetch[31:26] == OP_ADDI) begin
               vs   = cpu_gpr[cpu_prefetch[25:21]];
               simm = {{16{cpu_prefetch[15]}}, cpu_prefetch[15:0]};
               sum  = vs + simm;
               if (vs[31] == simm[31] && sum[31] != vs[31]) begin
                  cpu_prefetch[31:26] = OP_ADDI_NOTRAP;
                  word_feed_q[$].word[31:26] = OP_ADDI_NOTRAP;
               end
            end
         end
      end
   endtask

   task automatic wait_idle();
      while (word_feed_q.size() != 0 || rsp_due_q.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reset_pc(word_type v);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      cpu_start_pc = v;
      cpu_pc       = v;
      n_cfg++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.req_type  <= REQ_CYCLE;
         req_bus.data_word <= '0;
         gap_left = 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            rsp_due_q.push_back(word_feed_q[0].rsp);
            if (word_feed_q[0].kind == REQ_LOAD) n_loads++;
            void'(word_feed_q.pop_front());
            n_words++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (word_feed_q.size() == 0 ||
                      (word_feed_q[0].drain && rsp_due_q.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 3);
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid     <= 1'b1;
            req_bus.req_type  <= word_feed_q[0].kind;
            req_bus.data_word <= word_feed_q[0].word;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_due_q.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("%0t: response with none due: fetch %h op %0d addr %h wdata %h st %0d",
                           $realtime, rsp_bus.fetch_addr, rsp_bus.bus_op, rsp_bus.bus_addr,
                           rsp_bus.bus_wdata, rsp_bus.status);
            end else begin
               if (rsp_bus.fetch_addr !== rsp_due_q[0].fetch_addr ||
                   rsp_bus.bus_op     !== rsp_due_q[0].bus_op ||
                   rsp_bus.bus_addr   !== rsp_due_q[0].bus_addr ||
                   rsp_bus.bus_wdata  !== rsp_due_q[0].bus_wdata ||
                   rsp_bus.status     !== rsp_due_q[0].status) begin
                  n_bad++;
                  if (n_bad <= 10) begin
                     $display("%0t: mismatch on response %0d", $realtime, n_checked);
                     $display("   exp fetch %h op %0d addr %h wdata %h st %0d",
                              rsp_due_q[0].fetch_addr, rsp_due_q[0].bus_op,
                              rsp_due_q[0].bus_addr, rsp_due_q[0].bus_wdata,
                              rsp_due_q[0].status);
                     $display("   got fetch %h op %0d addr %h wdata %h st %0d",
                              rsp_bus.fetch_addr, rsp_bus.bus_op, rsp_bus.bus_addr,
                              rsp_bus.bus_wdata, rsp_bus.status);
                  end
               end
               void'(rsp_due_q.pop_front());
               n_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      fault_kind_type fault;
      logic [5:0]  opc;
      logic [5:0]  fn;
      reg_idx_type sel;
      word_type    bad_word;
      int          k;

      reset             <= 1'b1;
      csr_bus.valid     <= 1'b0;
      csr_bus.data      <= '0;
      calm      = 1'b0;
      n_words   = 0;
      n_loads   = 0;
      n_checked = 0;
      n_bad     = 0;
      n_cfg     = 0;

      cpu_gpr[0] = '0;
      for (k = 1; k < 32; k++) cpu_gpr[k] = FILL_VALUE;
      cpu_start_pc  = RESET_PC;
      cpu_pc        = RESET_PC;
      cpu_prefetch  = '0;
      cpu_sr        = '0;
      cpu_load_reg  = '0;
      cpu_load_val  = '0;
      cpu_wait_load = 1'b0;
      cpu_halted    = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed program from the reset start address
      feed_insn(enc_i(OP_SW, 5'd10, 5'd9, 16'h0000), 0);           // reset fill values
      feed_insn(enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF), 0);
      feed_insn(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF), 0);
      feed_insn(enc_r(5'd0, 5'd1, 5'd2, 5'd31, FN_SLL), 0);
      feed_insn(enc_r(5'd2, 5'd1, 5'd3, 5'd0, FN_OR), 0);
      feed_insn(enc_i(OP_ADDI_NOTRAP, 5'd0, 5'd4, 16'h8000), 0);
      feed_insn(enc_i(OP_ADDI_NOTRAP, 5'd0, 5'd5, 16'h7FFF), 0);
      feed_insn(enc_i(OP_ADDI, 5'd2, 5'd6, 16'h7FFF), 0);
      feed_insn(enc_i(OP_ADDI, 5'd1, 5'd6, 16'h8000), 0);
      feed_insn(enc_i(OP_LW, 5'd1, 5'd7, 16'h0004), 0);
      feed_insn(enc_i(OP_ADDI_NOTRAP, 5'd7, 5'd7, 16'h0001), 32'hFFFF_FFFF); // delay slot wins
      feed_insn(enc_i(OP_LW, 5'd0, 5'd8, 16'h0000), 0);
      feed_insn(enc_r(5'd8, 5'd0, 5'd9, 5'd0, FN_OR), 32'h0000_0000);      // sees old r8
      feed_insn(enc_i(OP_LW, 5'd2, 5'd0, 16'hFFFC), 0);
      feed_insn(enc_i(OP_SW, 5'd2, 5'd8, 16'h8000), $urandom());        // load to r0 dropped
      feed_insn({OP_J, 26'h3FF_FFFF}, 0);
      feed_insn(32'h0000_0000, 0);
      feed_insn(enc_i(OP_BNE, 5'd1, 5'd0, 16'hFFFF), 0);
      feed_insn(enc_i(OP_BNE, 5'd0, 5'd0, 16'h7FFF), 0);
      feed_insn(enc_i(OP_LUI, 5'd0, 5'd10, 16'h0001), 0);
      feed_insn(enc_mtc0(5'd10), 0);                                  // isolate cache
      feed_insn(enc_i(OP_LW, 5'd0, 5'd11, 16'h0000), 0);
      feed_insn(enc_i(OP_SW, 5'd0, 5'd1, 16'h0000), 0);
      feed_insn(enc_mtc0(5'd0), 0);
      feed_insn(enc_i(OP_LW, 5'd1, 5'd12, 16'h0010), 0);
      feed(REQ_LOAD, 32'hA5A5_5A5A, 1'b0);                         // no load waiting
      feed(REQ_CYCLE, 32'h0000_0000, 1'b0);
      feed(REQ_CYCLE, $urandom(), 1'b0);                           // load still waiting
      feed(REQ_LOAD, $urandom(), 1'b0);
      feed_insn(32'h0000_0000, 0);
      wait_idle();

      write_reset_pc(32'hFFFF_FFFF);
      random_phase(340);
      wait_idle();

      write_reset_pc(32'h0000_0000);
      random_phase(340);
      wait_idle();

      write_reset_pc($urandom());
      random_phase(340);
      wait_idle();

      // last phase runs without gaps or stalls
      calm = 1'b1;
      write_reset_pc({30'($urandom()), 2'b00});
      random_phase(340);

      // one halting fault, after which every word is ignored
      fault = fault_kind_type'($urandom_range(0, 5));
      bad_word = '0;
      feed_insn(enc_mtc0(5'd0), rand_data());
      case (fault)
         FLT_OVF_UP: begin
            feed_insn(enc_i(OP_LUI, 5'd0, 5'd20, 16'h7FFF), rand_data());
            feed_insn(enc_i(OP_ORI, 5'd20, 5'd20, 16'hFFFF), rand_data());
            bad_word = enc_i(OP_ADDI, 5'd20, 5'd21, 16'h0001);
         end
         FLT_OVF_DOWN: begin
            feed_insn(enc_i(OP_LUI, 5'd0, 5'd20, 16'h8000), rand_data());
            feed_insn(enc_i(OP_ORI, 5'd20, 5'd20, 16'h0000), rand_data());
            bad_word = enc_i(OP_ADDI, 5'd20, 5'd21, 16'hFFFF);
         end
         FLT_OPCODE: begin
            do opc = 6'($urandom_range(0, 63));
            while (opc inside {OP_SPECIAL, OP_J, OP_BNE, OP_ADDI, OP_ADDI_NOTRAP, OP_ORI,
                               OP_LUI, OP_COP0, OP_LW, OP_SW});
            bad_word = {opc, 26'($urandom())};
         end
         FLT_FUNCT: begin
            do fn = 6'($urandom_range(0, 63)); while (fn inside {FN_SLL, FN_OR});
            bad_word = {OP_SPECIAL, 20'($urandom()), fn};
         end
         FLT_COP_OP: begin
            do sel = reg_idx_type'($urandom_range(0, 31)); while (sel == COP_MTC0);
            bad_word = {OP_COP0, sel, 21'($urandom())};
         end
         default: begin
            do sel = reg_idx_type'($urandom_range(0, 31)); while (sel == SR_INDEX);
            bad_word = {OP_COP0, COP_MTC0, 5'($urandom()), sel, 11'($urandom())};
         end
      endcase
      feed_insn(enc_i(OP_LW, 5'd0, 5'd22, 16'h0000), rand_data());
      feed_insn(bad_word, rand_data());
      feed_insn(32'h0000_0000, rand_data());
      for (k = 0; k < 8; k++) feed(k[0] ? REQ_LOAD : REQ_CYCLE, $urandom(), 1'b0);

      wait_idle();
      repeat (10) @(posedge clock);

      $display("covered %0d request words (%0d load returns), %0d responses checked",
               n_words, n_loads, n_checked);
      $display("start address written %0d times; closing fault %s, %0d mismatches",
               n_cfg, fault.name(), n_bad);
      if (n_bad == 0 && rsp_due_q.size() == 0) begin
         $display("mips_r3000_subset_core test passed");
      end else begin
         $display("mips_r3000_subset_core test failed");
      end
      $finish;
   end

endmodule
